@@ hw/rtl/tdph_pkg.sv @@
// Shared constants, command/status types and the child search for the tree walker.
package tdph_pkg;

  localparam int MAX_NODES  = 32;
  localparam int NODE_COUNT = 32;
  localparam int NODE_W     = 5;
  localparam int CH_W       = 6;
  localparam int HGT_W      = 6;
  localparam int CNT_W      = 6;
  localparam int SP_W       = $clog2(MAX_NODES + 1);
  localparam int STK_AW     = $clog2(MAX_NODES);

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_WALK = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load_edge;
    logic start;
    logic pop;
    logic cut;
    logic push;
    logic finish;
  } tdph_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic found;
    logic cut_now;
    logic pop_last;
    logic slot_free;
  } tdph_stat_t;

  // Lowest set bit of row at or above from; NODE_COUNT when none
  function automatic logic [CH_W-1:0] first_set(input logic [NODE_COUNT-1:0] row,
                                                input logic [CH_W-1:0] from);
    logic [CH_W-1:0] res;
    res = CH_W'(NODE_COUNT);
    for (int i = NODE_COUNT - 1; i >= 0; i--) begin
      if (row[i] && (CH_W'(i) >= from)) begin
        res = CH_W'(i);
      end
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/tree_dfs_preorder_and_height.sv @@
// Top level of the tree walker: stream ports, register port, controller and datapath.
// An edge request is written to the adjacency matrix straight from idle. A walk request takes a
// start step, one step per stack push or pop, and a final result step; the datapath does a
// single stack step per cycle, but a push or the result waits while the output register is full.
// One request at a time; output back-pressure stalls the walk. Reset (rst_n, synchronous,
// active low) clears the adjacency matrix, the stack pointer and the output valid; root = 1.
module tree_dfs_preorder_and_height
  import tdph_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [4:0] parent, [9:5] child, rest zero
  input  logic [0:0]  in_tuser,   // [0] op (0 add edge, 1 walk)
  // Visited nodes
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [4:0] node, [10:5] height, rest zero
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // [0] overflow
  // Register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic REG_ROOT = 1'b0;

  logic [NODE_W-1:0] root_r;
  tdph_cmd_t         cmd;
  tdph_stat_t        stat;
  logic [NODE_W-1:0] node;
  logic [HGT_W-1:0]  height;
  logic              ovf;

  assign cfg_pready = 1'b1;

  // Root register; only word 0 is decoded, other words read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= NODE_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_ROOT)) begin
      root_r <= cfg_pwdata[NODE_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_ROOT) ? {{(32-NODE_W){1'b0}}, root_r} : '0;

  tdph_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser[0]),
    .stat      (stat),
    .cmd       (cmd)
  );

  tdph_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .root        (root_r),
    .edge_parent (in_tdata[4:0]),
    .edge_child  (in_tdata[9:5]),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_node    (node),
    .out_height  (height),
    .out_last    (out_tlast),
    .out_ovf     (ovf)
  );

  // Pack the result fields, lowest field first
  assign out_tdata = {5'b0, height, node};
  assign out_tuser = ovf;

endmodule

@@ hw/rtl/tdph_ctrl.sv @@
// Controller state machine for the tree walker: sequences edge writes, stack steps and the final result.
module tdph_ctrl
  import tdph_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       in_op,
  input  tdph_stat_t stat,
  output tdph_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_op == OP_WALK) begin
            cmd.start = 1'b1;
            state_nxt = S_STEP;
          end else begin
            cmd.load_edge = 1'b1;
          end
        end
      end
      S_STEP: begin
        priority if (!stat.found) begin
          cmd.pop = 1'b1;
          if (stat.pop_last) begin
            state_nxt = S_FIN;
          end
        end else if (stat.cut_now) begin
          cmd.cut   = 1'b1;
          state_nxt = S_FIN;
        end else if (stat.slot_free) begin
          cmd.push = 1'b1;
        end else begin
          // hold the step until the output register frees
          state_nxt = S_STEP;
        end
      end
      S_FIN: begin
        if (stat.slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/tdph_dp.sv @@
// Datapath for the tree walker: adjacency matrix, walk stack, pending result and output register.
module tdph_dp
  import tdph_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  tdph_cmd_t         cmd,
  output tdph_stat_t        stat,
  input  logic [NODE_W-1:0] root,
  input  logic [NODE_W-1:0] edge_parent,
  input  logic [NODE_W-1:0] edge_child,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [NODE_W-1:0] out_node,
  output logic [HGT_W-1:0]  out_height,
  output logic              out_last,
  output logic              out_ovf
);

  logic [NODE_COUNT-1:0] adj_r [NODE_COUNT];
  logic [NODE_W-1:0]     stk_node_r [MAX_NODES];
  logic [CH_W-1:0]       stk_nc_r [MAX_NODES];
  logic [SP_W-1:0]       sp_r;
  logic [SP_W-1:0]       depth_r;
  logic [CNT_W-1:0]      count_r;
  logic                  cut_r;
  logic [NODE_W-1:0]     pend_r;
  logic                  out_valid_r;
  logic [NODE_W-1:0]     out_node_r;
  logic [HGT_W-1:0]      out_height_r;
  logic                  out_last_r;
  logic                  out_ovf_r;

  logic [SP_W-1:0]       sp_dec;
  logic [SP_W-1:0]       sp_inc;
  logic [STK_AW-1:0]     top_idx;
  logic [STK_AW-1:0]     push_idx;
  logic [NODE_W-1:0]     top_node;
  logic [CH_W-1:0]       srch;
  logic [NODE_W-1:0]     next_child;
  logic [CH_W-1:0]       next_from;

  assign sp_dec     = sp_r - SP_W'(1);
  assign sp_inc     = sp_r + SP_W'(1);
  assign top_idx    = sp_dec[STK_AW-1:0];
  assign push_idx   = sp_r[STK_AW-1:0];
  assign top_node   = stk_node_r[top_idx];
  assign srch       = first_set(adj_r[top_node], stk_nc_r[top_idx]);
  assign next_child = srch[NODE_W-1:0];
  assign next_from  = srch + CH_W'(1);

  assign stat.found     = (srch != CH_W'(NODE_COUNT));
  assign stat.cut_now   = (count_r >= CNT_W'(NODE_COUNT)) || (sp_r >= SP_W'(MAX_NODES));
  assign stat.pop_last  = (sp_r == SP_W'(1));
  assign stat.slot_free = !out_valid_r || out_tready;

  // Adjacency matrix, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        adj_r[i] <= '0;
      end
    end else if (cmd.load_edge) begin
      adj_r[edge_parent][edge_child] <= 1'b1;
    end
  end

  // Walk stack entries
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      stk_node_r[0] <= root;
      stk_nc_r[0]   <= '0;
    end
    if (cmd.pop) begin
      stk_nc_r[top_idx] <= CH_W'(NODE_COUNT);
    end
    if (cmd.cut) begin
      stk_nc_r[top_idx] <= next_from;
    end
    if (cmd.push) begin
      stk_nc_r[top_idx]    <= next_from;
      stk_node_r[push_idx] <= next_child;
      stk_nc_r[push_idx]   <= '0;
    end
  end

  // Walk control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r    <= '0;
      depth_r <= '0;
      count_r <= '0;
      cut_r   <= 1'b0;
    end else begin
      if (cmd.start) begin
        sp_r    <= SP_W'(1);
        depth_r <= SP_W'(1);
        count_r <= CNT_W'(1);
        cut_r   <= 1'b0;
      end
      if (cmd.pop) begin
        sp_r <= sp_dec;
      end
      if (cmd.cut) begin
        cut_r <= 1'b1;
      end
      if (cmd.push) begin
        sp_r    <= sp_inc;
        count_r <= count_r + CNT_W'(1);
        if (sp_inc > depth_r) begin
          depth_r <= sp_inc;
        end
      end
      if (cmd.finish) begin
        sp_r <= '0;
      end
    end
  end

  // Pending result: held until the next visit or the end of the walk
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pend_r <= root;
    end else if (cmd.push) begin
      pend_r <= next_child;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push || cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_node_r   <= pend_r;
      out_height_r <= '0;
      out_last_r   <= 1'b0;
      out_ovf_r    <= 1'b0;
    end else if (cmd.finish) begin
      out_node_r   <= pend_r;
      out_height_r <= HGT_W'(depth_r);
      out_last_r   <= 1'b1;
      out_ovf_r    <= cut_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_node   = out_node_r;
  assign out_height = out_height_r;
  assign out_last   = out_last_r;
  assign out_ovf    = out_ovf_r;

endmodule
